### design/fdbs_pkg.sv
// ----------------------------------------------------------------------------
// fdbs_pkg - shared types and constants for the fractional dive selector
// Fixed-point widths, score width, penalty factor and the stage record.
// ----------------------------------------------------------------------------
package fdbs_pkg;

  // Field widths
  localparam int COLUMN_BITS   = 16;
  localparam int FRACTION_BITS = 24;
  localparam int VALUE_BITS    = 56;
  localparam int TOL_BITS      = 24;
  localparam int COL_OUT_BITS  = 17;
  localparam int ROUND_BITS    = 2;

  // Distance to nearest integer never exceeds one half, so it fits the
  // fraction width; the penalty factor adds ten bits.
  localparam int DIST_BITS     = FRACTION_BITS;
  localparam int PENALTY_BITS  = 10;
  localparam int SCORE_BITS    = DIST_BITS + PENALTY_BITS;
  localparam int CMP_BITS      = (DIST_BITS > TOL_BITS) ? DIST_BITS : TOL_BITS;

  localparam logic [PENALTY_BITS-1:0] PENALTY     = PENALTY_BITS'(1000);
  localparam logic [SCORE_BITS-1:0]   SCORE_MAX   = '1;
  localparam logic [TOL_BITS-1:0]     TOL_RESET   = TOL_BITS'(17);

  // Configuration register map (byte addresses)
  localparam int PADDR_BITS = 2;
  localparam logic [PADDR_BITS-1:0] ADDR_TOL = PADDR_BITS'(0);

  // Round direction codes as driven on the result port
  localparam logic [ROUND_BITS-1:0] ROUND_DOWN = 2'b11;
  localparam logic [ROUND_BITS-1:0] ROUND_UP   = 2'b01;

  // Column code for "no candidate"
  localparam logic [COL_OUT_BITS-1:0] COL_NONE = '1;

  // Scored request handed from the score stage to the select stage
  typedef struct packed {
    logic                   valid;
    logic [COLUMN_BITS-1:0] column;
    logic [SCORE_BITS-1:0]  score;
    logic                   dir_up;
    logic                   fractional;
    logic                   both_locked;
    logic                   last;
  } score_item_t;

endpackage

### design/fdbs_cfg.sv
// ----------------------------------------------------------------------------
// fdbs_cfg - APB-style configuration register
// Holds the integer tolerance; writes complete in the access phase.
// ----------------------------------------------------------------------------
module fdbs_cfg
  import fdbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [TOL_BITS-1:0]   tolerance
);

  logic [TOL_BITS-1:0] tol_r;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TOL);

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (wr_en) begin
      tol_r <= pwdata[TOL_BITS-1:0];
    end
  end

  // Read mux
  always_comb begin
    if (paddr == ADDR_TOL) begin
      prdata = {{(32-TOL_BITS){1'b0}}, tol_r};
    end else begin
      prdata = '0;
    end
  end

  assign tolerance = tol_r;

endmodule

### design/fdbs_score.sv
// ----------------------------------------------------------------------------
// fdbs_score - input register and scoring stage
// Takes the fraction, finds distance and direction to the nearer integer,
// checks it against the tolerance and applies the non-binary penalty.
// ----------------------------------------------------------------------------
module fdbs_score
  import fdbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  logic                   in_valid,
  input  logic [COLUMN_BITS-1:0] in_column,
  input  logic [VALUE_BITS-1:0]  in_value,
  input  logic                   in_down_locked,
  input  logic                   in_up_locked,
  input  logic                   in_is_binary,
  input  logic                   in_last,
  input  logic [TOL_BITS-1:0]    tolerance,
  output score_item_t            item
);

  // Input register
  logic                     a_valid_r;
  logic [COLUMN_BITS-1:0]   a_column_r;
  logic [FRACTION_BITS-1:0] a_frac_r;
  logic                     a_both_r;
  logic                     a_binary_r;
  logic                     a_last_r;

  // Combinational scoring
  logic                     dir_up;
  logic [DIST_BITS-1:0]     frac_dist;
  logic                     fractional;
  logic [SCORE_BITS-1:0]    score;

  score_item_t              item_r;
  score_item_t              item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_column_r <= in_column;
      a_frac_r   <= in_value[FRACTION_BITS-1:0];
      a_both_r   <= in_down_locked && in_up_locked;
      a_binary_r <= in_is_binary;
      a_last_r   <= in_last;
    end
  end

  // Distance: frac below one half rounds down, else up by (one - frac),
  // which is the two's complement of frac in the fraction width.
  assign dir_up     = a_frac_r[FRACTION_BITS-1];
  assign frac_dist  = dir_up ? DIST_BITS'(~a_frac_r + 1'b1) : DIST_BITS'(a_frac_r);
  assign fractional = CMP_BITS'(frac_dist) > CMP_BITS'(tolerance);
  assign score      = a_binary_r ? SCORE_BITS'(frac_dist)
                                 : SCORE_BITS'(frac_dist) * SCORE_BITS'(PENALTY);

  always_comb begin
    item_nxt             = item_r;
    item_nxt.valid       = a_valid_r;
    item_nxt.column      = a_column_r;
    item_nxt.score       = score;
    item_nxt.dir_up      = dir_up;
    item_nxt.fractional  = fractional;
    item_nxt.both_locked = a_both_r;
    item_nxt.last        = a_last_r;
  end

  // Score register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

### design/fdbs_select.sv
// ----------------------------------------------------------------------------
// fdbs_select - running minimum and result register
// Keeps the best score, column and direction of the scan and the
// all-roundable flag; emits all but the score on the last request and clears.
// ----------------------------------------------------------------------------
module fdbs_select
  import fdbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  score_item_t             item,
  output logic                    out_valid,
  output logic [COL_OUT_BITS-1:0] out_best_column,
  output logic [ROUND_BITS-1:0]   out_best_round,
  output logic                    out_all_roundable
);

  // Scan state
  logic [SCORE_BITS-1:0]   best_score_r, best_score_nxt;
  logic [COL_OUT_BITS-1:0] best_col_r,   best_col_nxt;
  logic                    best_up_r,    best_up_nxt;
  logic                    roundable_r,  roundable_nxt;

  // Result register
  logic                    out_valid_r;
  logic [COL_OUT_BITS-1:0] out_col_r;
  logic [ROUND_BITS-1:0]   out_round_r;
  logic                    out_round_all_r;

  logic                    eligible;
  logic                    lock_now;
  logic [SCORE_BITS-1:0]   base_score;
  logic                    win;

  // First both-locked candidate restarts the minimum
  assign eligible   = item.valid && item.fractional && (roundable_r || item.both_locked);
  assign lock_now   = eligible && roundable_r && item.both_locked;
  assign base_score = lock_now ? SCORE_MAX : best_score_r;
  assign win        = eligible && (item.score < base_score);

  always_comb begin
    best_score_nxt = base_score;
    best_col_nxt   = best_col_r;
    best_up_nxt    = best_up_r;
    roundable_nxt  = roundable_r && !lock_now;
    if (win) begin
      best_score_nxt = item.score;
      best_col_nxt   = {{(COL_OUT_BITS-COLUMN_BITS){1'b0}}, item.column};
      best_up_nxt    = item.dir_up;
    end
  end

  // State update; cleared after the last request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= SCORE_MAX;
      best_col_r   <= COL_NONE;
      best_up_r    <= 1'b0;
      roundable_r  <= 1'b1;
    end else if (advance && item.valid) begin
      if (item.last) begin
        best_score_r <= SCORE_MAX;
        best_col_r   <= COL_NONE;
        best_up_r    <= 1'b0;
        roundable_r  <= 1'b1;
      end else begin
        best_score_r <= best_score_nxt;
        best_col_r   <= best_col_nxt;
        best_up_r    <= best_up_nxt;
        roundable_r  <= roundable_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item.valid && item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.valid && item.last) begin
      out_col_r       <= best_col_nxt;
      out_round_r     <= best_up_nxt ? ROUND_UP : ROUND_DOWN;
      out_round_all_r <= roundable_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_column   = out_col_r;
  assign out_best_round    = out_round_r;
  assign out_all_roundable = out_round_all_r;

endmodule

### design/fractional_dive_branch_select.sv
// Latency: a result passes the input, score and result registers after its last request is accepted.
// Throughput: one request per cycle while no result is held; the running minimum updates on each request.
// The only hold-off is a result waiting on out_stall, which stalls all stages.
// Reset (rst_n, synchronous): pipeline empty, scan cleared, tolerance = 17.
// ----------------------------------------------------------------------------
// fractional_dive_branch_select - branching variable selector, top level
// Scores fractional variables and keeps the best one per scan.
// ----------------------------------------------------------------------------
module fractional_dive_branch_select
  import fdbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COLUMN_BITS-1:0]  in_column,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  logic                    in_down_locked,
  input  logic                    in_up_locked,
  input  logic                    in_is_binary,
  input  logic                    in_last,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COL_OUT_BITS-1:0] out_best_column,
  output logic [ROUND_BITS-1:0]   out_best_round,
  output logic                    out_all_roundable,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_BITS-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic                advance;
  logic [TOL_BITS-1:0] tolerance;
  score_item_t         item;

  // Whole pipeline moves unless a result is held
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  fdbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tolerance (tolerance)
  );

  fdbs_score u_score (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .in_valid       (in_valid),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_down_locked (in_down_locked),
    .in_up_locked   (in_up_locked),
    .in_is_binary   (in_is_binary),
    .in_last        (in_last),
    .tolerance      (tolerance),
    .item           (item)
  );

  fdbs_select u_select (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .item              (item),
    .out_valid         (out_valid),
    .out_best_column   (out_best_column),
    .out_best_round    (out_best_round),
    .out_all_roundable (out_all_roundable)
  );

endmodule
